// ===== src/lfu_set_assoc_cache_policy_assert.svh =====
// ----------------------------------------------------------------------------
// lfu_set_assoc_cache_policy_assert
// assertion macros for the lfu cache policy block
// ----------------------------------------------------------------------------
`ifndef LFU_SET_ASSOC_CACHE_POLICY_ASSERT_SVH
`define LFU_SET_ASSOC_CACHE_POLICY_ASSERT_SVH

// same-cycle implication
`define LFUC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lfuc assertion failed");

// next-cycle implication
`define LFUC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lfuc assertion failed");

`endif

// ===== src/lfuc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfuc_pkg
// shared constants and types of the lfu cache policy block
// ----------------------------------------------------------------------------
package lfuc_pkg;

	localparam int MAX_WAYS   = 8;
	localparam int MAX_SETS   = 64;
	localparam int BLOCK_IDS  = 1024;
	localparam int BLOCK_W    = 10;
	localparam int WAY_W      = $clog2(MAX_WAYS);
	localparam int SET_W      = $clog2(MAX_SETS);
	localparam int CNT_W      = 16;
	localparam int MISS_W     = 32;
	localparam int WAYS_CFG_W = 4;
	localparam int SETS_CFG_W = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_WAYS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SETS = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_LOOK,
		ST_SREQ,
		ST_SCMP,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [MAX_WAYS-1:0][BLOCK_W-1:0] tags;
		logic [MAX_WAYS-1:0]              valid;
	} row_t;

	typedef struct packed {
		logic             rd_en;
		logic [SET_W-1:0] rd_addr;
		logic             wr_en;
		logic [SET_W-1:0] wr_addr;
		row_t             wr_row;
	} tag_req_t;

	typedef struct packed {
		logic               rd_en;
		logic [BLOCK_W-1:0] rd_addr;
		logic               wr_en;
		logic [BLOCK_W-1:0] wr_addr;
		logic [CNT_W-1:0]   wr_data;
	} cnt_req_t;

endpackage

// ===== src/lfuc_set_mod.sv =====
// ----------------------------------------------------------------------------
// lfuc_set_mod
// block number modulo set count, restoring division one bit per cycle
// ----------------------------------------------------------------------------
module lfuc_set_mod import lfuc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [BLOCK_W-1:0]    dividend,
	input  logic [SETS_CFG_W-1:0] divisor,
	output logic                  done,
	output logic [SET_W-1:0]      rem
);

	localparam int STEP_W = $clog2(BLOCK_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [STEP_W-1:0]     step_q;
	logic [SET_W-1:0]      rem_q;
	logic [BLOCK_W-1:0]    dvd_q;
	logic [SETS_CFG_W-1:0] div_q;
	logic [SET_W:0]        trial;
	logic [SET_W:0]        trial_sub;

	assign trial     = {rem_q, dvd_q[BLOCK_W-1]};
	assign trial_sub = (trial >= (SET_W+1)'(div_q)) ? trial - (SET_W+1)'(div_q) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(BLOCK_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= trial_sub[SET_W-1:0];
			dvd_q <= {dvd_q[BLOCK_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// ===== src/lfuc_tag_ram.sv =====
// ----------------------------------------------------------------------------
// lfuc_tag_ram
// one row per set holding all tags and line valid bits, row written flags
// ----------------------------------------------------------------------------
module lfuc_tag_ram import lfuc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  tag_req_t req,
	output row_t     rd_row
);

	row_t                mem [MAX_SETS];
	row_t                rd_raw_q;
	logic [MAX_SETS-1:0] row_written_q;
	logic                rd_written_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_written_q <= '0;
			rd_written_q  <= 1'b0;
		end else begin
			if (req.rd_en) begin
				rd_written_q <= row_written_q[req.rd_addr];
			end
			if (req.wr_en) begin
				row_written_q[req.wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_row;
		end
		if (req.rd_en) begin
			rd_raw_q <= mem[req.rd_addr];
		end
	end

	// a row never written holds no valid line
	assign rd_row.tags  = rd_raw_q.tags;
	assign rd_row.valid = rd_raw_q.valid & {MAX_WAYS{rd_written_q}};

endmodule

// ===== src/lfuc_count_ram.sv =====
// ----------------------------------------------------------------------------
// lfuc_count_ram
// per block reference counts, cleared by a sweep after reset
// ----------------------------------------------------------------------------
module lfuc_count_ram import lfuc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cnt_req_t         req,
	output logic [CNT_W-1:0] rd_data,
	output logic             busy
);

	logic [CNT_W-1:0]   mem [BLOCK_IDS];
	logic [BLOCK_W-1:0] clr_ptr_q;
	logic               busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_ptr_q <= '0;
		end else if (busy_q) begin
			clr_ptr_q <= clr_ptr_q + 1'b1;
			if (clr_ptr_q == BLOCK_W'(BLOCK_IDS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_ptr_q] <= '0;
		end else if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

	assign busy = busy_q;

endmodule

// ===== src/lfu_set_assoc_cache_policy.sv =====
// ----------------------------------------------------------------------------
// lfu_set_assoc_cache_policy
// set-associative cache model with least-frequently-used replacement
// ----------------------------------------------------------------------------
// channel  | direction | signals
// in       | input     | in_valid, in_ready, block_number
// out      | output    | out_valid, out_ready, hit, evicted_valid, evicted_block, miss_total
// cfg      | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// one transaction at a time: the 10-step set modulo runs first, and on an
// eviction the count of each way is then read in turn through the single
// read port of the count memory
// after reset a clearing pass over all 1024 count memory entries holds in_ready low
// a stalled result is held in the output register while the next transaction
// is accepted; the write back waits only if that register is still full
// ----------------------------------------------------------------------------
module lfu_set_assoc_cache_policy import lfuc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [BLOCK_W-1:0]    block_number,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  hit,
	output logic                  evicted_valid,
	output logic [BLOCK_W-1:0]    evicted_block,
	output logic [MISS_W-1:0]     miss_total,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	state_t                state_q, state_d;
	logic [WAYS_CFG_W-1:0] ways_cfg_q;
	logic [SETS_CFG_W-1:0] sets_cfg_q;
	logic [WAYS_CFG_W-1:0] ways_eff;
	logic [SETS_CFG_W-1:0] sets_eff;
	logic [WAYS_CFG_W-1:0] wuse_q;
	logic [BLOCK_W-1:0]    block_q;
	logic [SET_W-1:0]      set_q;
	row_t                  row_q;
	logic [CNT_W-1:0]      own_cnt_q;
	logic                  hit_q;
	logic                  full_q;
	logic [WAY_W-1:0]      victim_q;
	logic [WAY_W-1:0]      scan_q;
	logic [CNT_W-1:0]      best_q;
	logic [MISS_W-1:0]     miss_q;
	logic                  out_valid_q;
	logic                  hit_out_q;
	logic                  ev_valid_q;
	logic [BLOCK_W-1:0]    ev_block_q;
	logic [MISS_W-1:0]     miss_out_q;
	logic                  start_q;

	logic                  mod_start;
	logic                  mod_done;
	logic [SET_W-1:0]      mod_rem;
	tag_req_t              tag_req;
	row_t                  rd_row;
	cnt_req_t              cnt_req;
	logic [CNT_W-1:0]      cnt_rd;
	logic                  clr_busy;
	logic                  accept;
	logic                  out_free;
	logic                  commit;
	logic [MAX_WAYS-1:0]   hit_vec;
	logic [MAX_WAYS-1:0]   empty_vec;
	logic [WAY_W-1:0]      first_empty;
	logic [MISS_W-1:0]     miss_next;
	logic [CNT_W-1:0]      own_next;
	row_t                  row_wr;

	// config clamping
	assign ways_eff = (ways_cfg_q == '0) ? WAYS_CFG_W'(1) :
		(ways_cfg_q > WAYS_CFG_W'(MAX_WAYS)) ? WAYS_CFG_W'(MAX_WAYS) : ways_cfg_q;
	assign sets_eff = (sets_cfg_q == '0) ? SETS_CFG_W'(1) :
		(sets_cfg_q > SETS_CFG_W'(MAX_SETS)) ? SETS_CFG_W'(MAX_SETS) : sets_cfg_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE) && !clr_busy;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign commit    = (state_q == ST_DONE) && out_free;

	lfuc_set_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (block_q),
		.divisor  (sets_eff),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	lfuc_tag_ram u_tag (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tag_req),
		.rd_row (rd_row)
	);

	lfuc_count_ram u_cnt (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (cnt_req),
		.rd_data (cnt_rd),
		.busy    (clr_busy)
	);

	// set lookup
	always_comb begin
		hit_vec     = '0;
		empty_vec   = '0;
		first_empty = '0;
		for (int w = 0; w < MAX_WAYS; w++) begin
			if (WAYS_CFG_W'(w) < wuse_q) begin
				hit_vec[w]   = rd_row.valid[w] && (rd_row.tags[w] == block_q);
				empty_vec[w] = !rd_row.valid[w];
			end
		end
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (empty_vec[w]) begin
				first_empty = WAY_W'(w);
			end
		end
	end

	assign miss_next = (miss_q == '1) ? miss_q : miss_q + 1'b1;
	assign own_next  = (own_cnt_q == '1) ? own_cnt_q : own_cnt_q + 1'b1;

	always_comb begin
		row_wr                  = row_q;
		row_wr.tags[victim_q]   = block_q;
		row_wr.valid[victim_q]  = 1'b1;
	end

	// next state and memory requests
	always_comb begin
		state_d         = state_q;
		mod_start       = start_q;
		tag_req         = '0;
		tag_req.rd_addr = mod_rem;
		tag_req.wr_addr = set_q;
		tag_req.wr_row  = row_wr;
		cnt_req         = '0;
		cnt_req.rd_addr = block_q;
		cnt_req.wr_addr = block_q;
		cnt_req.wr_data = own_next;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				if (mod_done) begin
					tag_req.rd_en = 1'b1;
					cnt_req.rd_en = 1'b1;
					state_d       = ST_LOOK;
				end
			end
			ST_LOOK: begin
				if (|hit_vec || |empty_vec) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SREQ;
				end
			end
			ST_SREQ: begin
				cnt_req.rd_en   = 1'b1;
				cnt_req.rd_addr = row_q.tags[scan_q];
				state_d         = ST_SCMP;
			end
			ST_SCMP: begin
				if (WAYS_CFG_W'(scan_q) == wuse_q - 1'b1) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SREQ;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cnt_req.wr_en = 1'b1;
					tag_req.wr_en = !hit_q;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ways_cfg_q  <= WAYS_CFG_W'(8);
			sets_cfg_q  <= SETS_CFG_W'(1);
			miss_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				case (cfg_index)
					REG_WAYS: ways_cfg_q <= cfg_data[WAYS_CFG_W-1:0];
					REG_SETS: sets_cfg_q <= cfg_data[SETS_CFG_W-1:0];
					default: begin
					end
				endcase
			end
			if (commit) begin
				out_valid_q <= 1'b1;
				if (!hit_q) begin
					miss_q <= miss_next;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// one-cycle start pulse after accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
		end else begin
			start_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			block_q <= block_number;
			wuse_q  <= ways_eff;
		end
		if (mod_done) begin
			set_q <= mod_rem;
		end
		if (state_q == ST_LOOK) begin
			row_q     <= rd_row;
			own_cnt_q <= cnt_rd;
			hit_q     <= |hit_vec;
			full_q    <= !(|hit_vec) && !(|empty_vec);
			victim_q  <= first_empty;
			scan_q    <= '0;
		end
		if (state_q == ST_SCMP) begin
			if (scan_q == '0 || cnt_rd < best_q) begin
				best_q   <= cnt_rd;
				victim_q <= scan_q;
			end
			scan_q <= scan_q + 1'b1;
		end
		if (commit) begin
			hit_out_q  <= hit_q;
			ev_valid_q <= full_q;
			ev_block_q <= full_q ? row_q.tags[victim_q] : '0;
			miss_out_q <= hit_q ? miss_q : miss_next;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = hit_out_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_block = ev_block_q;
	assign miss_total    = miss_out_q;

	`include "lfu_set_assoc_cache_policy_assert.svh"

	`LFUC_ASSERT_IMP(a_hit_no_evict, out_valid, !(hit && evicted_valid))
	`LFUC_ASSERT_IMP(a_evict_zero, out_valid && !evicted_valid, evicted_block == '0)
	`LFUC_ASSERT_NXT(a_accept_mod, accept, state_q == ST_MOD)
	`LFUC_ASSERT_NXT(a_miss_mono, 1'b1, miss_q >= $past(miss_q))

endmodule
